// ===== src/tlmd_pkg.sv =====
package tlmd_pkg;

  // Header layout: a 32-bit type followed by a 32-bit length, little endian.
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HDR_CNT_W    = 3;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  // Message type that carries a focus target in its first payload bytes.
  localparam logic [3:0]  FOCUS_TYPE  = 4'd4;
  localparam logic [30:0] FOCUS_BYTES = 31'd4;

  // Reset value of the maximum accepted type.
  localparam logic [3:0] MAX_TYPE_RESET = 4'd10;

  typedef struct packed {
    logic [3:0]         msg_type;
    logic [7:0]         payload_byte;
    logic               payload_valid;
    logic [30:0]        payload_index;
    logic               msg_last;
    logic               header_done;
    logic               type_error;
    logic               focus_valid;
    logic signed [31:0] focus_target;
  } result_t;

endpackage

// ===== src/type_length_message_deframer_top.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------
// in       | input     | in_valid_i / in_stall_o | rx_byte_i
// out      | output    | out_valid_o / out_stall_i | msg_type_o .. focus_target_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (max valid type)
//
// One byte is taken per cycle while in_stall_o is low; each byte yields exactly
// one result transfer. A byte passes through the input register and then the
// result register, with the combinational deframing step between them; the
// sustained rate is one byte per clock while the result side does not stall.
// Reset clears all control state and sets the maximum type to ten.
// A stall on the result side holds both registers and reaches in_stall_o
// combinationally only when both registers are occupied.
module type_length_message_deframer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         msg_type_o,
  output logic [7:0]         payload_byte_o,
  output logic               payload_valid_o,
  output logic [30:0]        payload_index_o,
  output logic               msg_last_o,
  output logic               header_done_o,
  output logic               type_error_o,
  output logic               focus_valid_o,
  output logic signed [31:0] focus_target_o
);

  import tlmd_pkg::*;

  logic       advance;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic [3:0] max_type_q;
  result_t    core_result;
  result_t    out_result;

  // The configuration register is always ready; the user must write it only when idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_type_q <= MAX_TYPE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_type_q <= cfg_data_i;
    end
  end

  // Input register: holds the received byte until the deframing step takes it.
  tlmd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  // Deframing step: header assembly, payload tracking and focus capture.
  // Its state advances only when the byte actually moves into the result register.
  tlmd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (stage_valid && advance),
    .byte_i     (stage_byte),
    .max_type_i (max_type_q),
    .result_o   (core_result)
  );

  // Result register: parts the result side from the input side.
  tlmd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .result_i    (core_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign msg_type_o      = out_result.msg_type;
  assign payload_byte_o  = out_result.payload_byte;
  assign payload_valid_o = out_result.payload_valid;
  assign payload_index_o = out_result.payload_index;
  assign msg_last_o      = out_result.msg_last;
  assign header_done_o   = out_result.header_done;
  assign type_error_o    = out_result.type_error;
  assign focus_valid_o   = out_result.focus_valid;
  assign focus_target_o  = out_result.focus_target;

endmodule

// ===== src/tlmd_in_reg.sv =====
module tlmd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  // The register may take a new byte when it is empty or its byte moves on.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== src/tlmd_core.sv =====
module tlmd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [3:0]          max_type_i,
  output tlmd_pkg::result_t   result_o
);

  import tlmd_pkg::*;

  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [55:0]          hdr_q, hdr_d;
  logic [30:0]          remain_q, remain_d;
  logic [3:0]           type_q, type_d;
  logic [30:0]          offset_q, offset_d;
  logic [31:0]          focus_q, focus_d;
  logic                 err_q, err_d;
  result_t              res;

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    hdr_d     = hdr_q;
    remain_d  = remain_q;
    type_d    = type_q;
    offset_d  = offset_q;
    focus_d   = focus_q;
    err_d     = err_q;
    res       = '0;

    if (step_i && !err_q) begin
      if (remain_q == '0) begin
        if (hdr_cnt_q == HDR_LAST) begin
          // Final header byte: the type is complete, the length top byte is this one.
          hdr_cnt_d = '0;
          if ((hdr_q[31:4] != '0) || (hdr_q[3:0] > max_type_i)) begin
            err_d = 1'b1;
          end else begin
            type_d          = hdr_q[3:0];
            remain_d        = byte_i[7] ? '0 : {byte_i[6:0], hdr_q[55:32]};
            offset_d        = '0;
            focus_d         = '0;
            res.header_done = 1'b1;
          end
        end else begin
          hdr_d[{hdr_cnt_q, 3'b000} +: 8] = byte_i;
          hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
        end
      end else begin
        res.payload_byte  = byte_i;
        res.payload_valid = 1'b1;
        res.payload_index = offset_q;
        if ((type_q == FOCUS_TYPE) && (offset_q < FOCUS_BYTES)) begin
          focus_d[{offset_q[1:0], 3'b000} +: 8] =
            focus_q[{offset_q[1:0], 3'b000} +: 8] | byte_i;
        end
        if (remain_q == 31'd1) begin
          res.msg_last = 1'b1;
          if (type_q == FOCUS_TYPE) begin
            res.focus_valid  = 1'b1;
            res.focus_target = focus_d;
          end
        end
        remain_d = remain_q - 31'd1;
        offset_d = offset_q + 31'd1;
      end
    end

    res.msg_type   = type_d;
    res.type_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      hdr_q     <= '0;
      remain_q  <= '0;
      type_q    <= '0;
      offset_q  <= '0;
      focus_q   <= '0;
      err_q     <= 1'b0;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      hdr_q     <= hdr_d;
      remain_q  <= remain_d;
      type_q    <= type_d;
      offset_q  <= offset_d;
      focus_q   <= focus_d;
      err_q     <= err_d;
    end
  end

  assign result_o = res;

endmodule

// ===== src/tlmd_out_reg.sv =====
module tlmd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tlmd_pkg::result_t result_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tlmd_pkg::result_t result_o
);

  import tlmd_pkg::*;

  logic    valid_q;
  result_t result_q;

  // The result register is free when empty or when its transfer completes now.
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
